// ===== rtl/cltt_pkg.sv =====
// Shared types and constants for the client liveness timeout table.
// No dependencies; used by every other file in rtl/.
package cltt_pkg;

  localparam int unsigned MaxClientsDef = 16;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned IdW           = 16;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [TimeW-1:0] CheckPeriodRst = 32'd5000;
  localparam logic [TimeW-1:0] DeadAfterRst   = 32'd10000;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEEN   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_FAIL  = 3'd1,
    ST_ALIVE = 3'd2,
    ST_CHECK = 3'd3,
    ST_DEAD  = 3'd4,
    ST_EMPTY = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHECK_PERIOD = 1'd0,
    CFG_DEAD_AFTER   = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_MIN,
    S_OUT,
    S_RESP_OK,
    S_RESP_FAIL,
    S_RESP_EMPTY
  } state_e;

  typedef enum logic [1:0] {
    RD_CNT,
    RD_NEXT,
    RD_ZERO
  } rd_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_load_pos;
    logic    find_chk;
    logic    min_upd;
    logic    wr_add;
    logic    wr_seen;
    logic    wr_shift;
    logic    count_dec;
    logic    out_entry;
    logic    out_resp;
    status_e resp_status;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_nz;
    logic cnt_lt_count;
    logic match;
    logic full;
    logic count_zero;
    logic found;
    logic out_free;
    logic shift_more;
    logic last_entry;
    cmd_e req_cmd;
  } dp_stat_t;

endpackage

// ===== rtl/cltt_req_if.sv =====
// Request channel: valid/ready handshake with command, client id and time.
// Depends on cltt_pkg for field widths.
interface cltt_req_if;
  logic                          valid;
  logic                          ready;
  logic [cltt_pkg::CmdW-1:0]     command;
  logic [cltt_pkg::IdW-1:0]      client_id;
  logic [cltt_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, command, client_id, now_ms, input ready);
  modport sink   (input valid, command, client_id, now_ms, output ready);
endinterface

// ===== rtl/cltt_rsp_if.sv =====
// Result channel: valid/ready handshake with status, id, wait time and last flag.
// Depends on cltt_pkg for field widths.
interface cltt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cltt_pkg::StatusW-1:0]  status;
  logic [cltt_pkg::IdW-1:0]      entry_id;
  logic [cltt_pkg::TimeW-1:0]    next_wait_ms;
  logic                          last;

  modport source (output valid, status, entry_id, next_wait_ms, last, input ready);
  modport sink   (input valid, status, entry_id, next_wait_ms, last, output ready);
endinterface

// ===== rtl/cltt_ctrl.sv =====
// Sequencer for the timeout table: search, insert, shift-down, scan passes.
// Depends on cltt_pkg; drives cltt_dp through ctrl_cmd_t.
module cltt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  cltt_pkg::cmd_e           in_cmd_i,
  output logic                     in_ready_o,
  input  cltt_pkg::dp_stat_t       stat_i,
  output cltt_pkg::ctrl_cmd_t      cmd_o
);

  cltt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cltt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.resp_status = cltt_pkg::ST_OK;
    cmd_o.rd_sel     = cltt_pkg::RD_CNT;
    in_ready_o       = 1'b0;

    unique case (state_q)
      cltt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          if (in_cmd_i == cltt_pkg::CMD_TICK) begin
            state_d = stat_i.count_zero ? cltt_pkg::S_RESP_EMPTY : cltt_pkg::S_MIN;
          end else begin
            state_d = cltt_pkg::S_FIND;
          end
        end
      end

      // read entry cnt, compare entry cnt-1 against the request id
      cltt_pkg::S_FIND: begin
        cmd_o.find_chk = 1'b1;
        cmd_o.cnt_inc  = stat_i.cnt_lt_count;
        if ((stat_i.cnt_nz && stat_i.match) || !stat_i.cnt_lt_count) begin
          state_d = cltt_pkg::S_DECIDE;
        end
      end

      cltt_pkg::S_DECIDE: begin
        unique case (stat_i.req_cmd)
          cltt_pkg::CMD_ADD: begin
            if (stat_i.found || stat_i.full) begin
              state_d = cltt_pkg::S_RESP_FAIL;
            end else begin
              cmd_o.wr_add = 1'b1;
              state_d      = cltt_pkg::S_RESP_OK;
            end
          end
          cltt_pkg::CMD_REMOVE: begin
            if (!stat_i.found) begin
              state_d = cltt_pkg::S_RESP_FAIL;
            end else begin
              cmd_o.cnt_load_pos = 1'b1;
              state_d            = cltt_pkg::S_SHIFT_RD;
            end
          end
          cltt_pkg::CMD_SEEN: begin
            if (!stat_i.found) begin
              state_d = cltt_pkg::S_RESP_FAIL;
            end else begin
              cmd_o.wr_seen = 1'b1;
              state_d       = cltt_pkg::S_RESP_OK;
            end
          end
          cltt_pkg::CMD_TICK: begin
            state_d = cltt_pkg::S_RESP_EMPTY;
          end
          default: begin
            state_d = cltt_pkg::S_RESP_FAIL;
          end
        endcase
      end

      cltt_pkg::S_SHIFT_RD: begin
        if (stat_i.shift_more) begin
          cmd_o.rd_sel = cltt_pkg::RD_NEXT;
          state_d      = cltt_pkg::S_SHIFT_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          state_d         = cltt_pkg::S_RESP_OK;
        end
      end

      cltt_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        state_d        = cltt_pkg::S_SHIFT_RD;
      end

      // first pass: least remaining time; ends with entry 0 being read
      cltt_pkg::S_MIN: begin
        cmd_o.min_upd = stat_i.cnt_nz;
        if (stat_i.cnt_lt_count) begin
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_sel  = cltt_pkg::RD_ZERO;
          cmd_o.cnt_clr = 1'b1;
          state_d       = cltt_pkg::S_OUT;
        end
      end

      // second pass: one result per entry, held while the sink stalls
      cltt_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_entry = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.rd_sel    = cltt_pkg::RD_NEXT;
          if (stat_i.last_entry) begin
            state_d = cltt_pkg::S_IDLE;
          end
        end
      end

      cltt_pkg::S_RESP_OK: begin
        cmd_o.resp_status = cltt_pkg::ST_OK;
        if (stat_i.out_free) begin
          cmd_o.out_resp = 1'b1;
          state_d        = cltt_pkg::S_IDLE;
        end
      end

      cltt_pkg::S_RESP_FAIL: begin
        cmd_o.resp_status = cltt_pkg::ST_FAIL;
        if (stat_i.out_free) begin
          cmd_o.out_resp = 1'b1;
          state_d        = cltt_pkg::S_IDLE;
        end
      end

      cltt_pkg::S_RESP_EMPTY: begin
        cmd_o.resp_status = cltt_pkg::ST_EMPTY;
        if (stat_i.out_free) begin
          cmd_o.out_resp = 1'b1;
          state_d        = cltt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cltt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cltt_dp.sv =====
// Datapath for the timeout table: entry memories, counters, config, result register.
// Depends on cltt_pkg; commanded by cltt_ctrl.
module cltt_dp #(
  parameter int unsigned MaxClients = cltt_pkg::MaxClientsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cltt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cltt_pkg::TimeW-1:0]        cfg_wdata_i,
  input  cltt_pkg::cmd_e                    in_cmd_i,
  input  logic [cltt_pkg::IdW-1:0]          in_id_i,
  input  logic [cltt_pkg::TimeW-1:0]        in_now_i,
  input  cltt_pkg::ctrl_cmd_t               cmd_i,
  output cltt_pkg::dp_stat_t                stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [cltt_pkg::StatusW-1:0]      out_status_o,
  output logic [cltt_pkg::IdW-1:0]          out_id_o,
  output logic [cltt_pkg::TimeW-1:0]        out_wait_o,
  output logic                              out_last_o
);

  localparam int unsigned CntW  = $clog2(MaxClients + 1);
  localparam int unsigned AddrW = (MaxClients > 1) ? $clog2(MaxClients) : 1;

  // configuration
  logic [cltt_pkg::TimeW-1:0] check_q, dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= cltt_pkg::CheckPeriodRst;
      dead_q  <= cltt_pkg::DeadAfterRst;
    end else if (cfg_we_i) begin
      unique case (cltt_pkg::cfg_idx_e'(cfg_idx_i))
        cltt_pkg::CFG_CHECK_PERIOD: check_q <= cfg_wdata_i;
        cltt_pkg::CFG_DEAD_AFTER:   dead_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured request
  cltt_pkg::cmd_e              req_cmd_q;
  logic [cltt_pkg::IdW-1:0]    req_id_q;
  logic [cltt_pkg::TimeW-1:0]  req_now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_cmd_q <= in_cmd_i;
      req_id_q  <= in_id_i;
      req_now_q <= in_now_i;
    end
  end

  // counters
  logic [CntW-1:0]  count_q, cnt_q, cnt_nxt;
  logic [AddrW-1:0] pos_q;
  logic             found_q;

  assign cnt_nxt = cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.wr_add) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CntW'(1);
      end

      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_load_pos) begin
        cnt_q <= CntW'(pos_q);
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_nxt;
      end

      if (cmd_i.load_req) begin
        found_q <= 1'b0;
      end else if (cmd_i.find_chk && stat_o.cnt_nz && stat_o.match) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find_chk && stat_o.cnt_nz && stat_o.match) begin
      pos_q <= AddrW'(cnt_q - CntW'(1));
    end
  end

  // entry memories, one write and one registered read a cycle
  logic [cltt_pkg::IdW-1:0]   ids_mem  [MaxClients];
  logic [cltt_pkg::TimeW-1:0] seen_mem [MaxClients];
  logic [cltt_pkg::IdW-1:0]   rd_id_q;
  logic [cltt_pkg::TimeW-1:0] rd_seen_q;
  logic [AddrW-1:0]           raddr;

  always_comb begin
    case (cmd_i.rd_sel)
      cltt_pkg::RD_NEXT: raddr = cnt_nxt[AddrW-1:0];
      cltt_pkg::RD_ZERO: raddr = '0;
      default:           raddr = cnt_q[AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_id_q   <= ids_mem[raddr];
    rd_seen_q <= seen_mem[raddr];
    if (cmd_i.wr_add) begin
      ids_mem[count_q[AddrW-1:0]]  <= req_id_q;
      seen_mem[count_q[AddrW-1:0]] <= req_now_q;
    end else if (cmd_i.wr_seen) begin
      seen_mem[pos_q] <= req_now_q;
    end else if (cmd_i.wr_shift) begin
      ids_mem[cnt_q[AddrW-1:0]]  <= rd_id_q;
      seen_mem[cnt_q[AddrW-1:0]] <= rd_seen_q;
    end
  end

  // timing arithmetic on the entry just read
  logic [cltt_pkg::TimeW-1:0] elapsed, remain, wait_q;
  cltt_pkg::status_e          entry_st;

  assign elapsed = req_now_q - rd_seen_q;
  assign remain  = (elapsed >= check_q) ? '0 : (check_q - elapsed);

  always_comb begin
    if (elapsed > dead_q) begin
      entry_st = cltt_pkg::ST_DEAD;
    end else if (elapsed > check_q) begin
      entry_st = cltt_pkg::ST_CHECK;
    end else begin
      entry_st = cltt_pkg::ST_ALIVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      wait_q <= check_q;
    end else if (cmd_i.min_upd && (remain < wait_q)) begin
      wait_q <= remain;
    end
  end

  // result register
  logic                       out_valid_q, out_last_q;
  cltt_pkg::status_e          out_status_q;
  logic [cltt_pkg::IdW-1:0]   out_id_q;
  logic [cltt_pkg::TimeW-1:0] out_wait_q;
  logic                       out_load;

  assign out_load = cmd_i.out_entry || cmd_i.out_resp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_entry) begin
      out_status_q <= entry_st;
      out_id_q     <= rd_id_q;
      out_wait_q   <= wait_q;
      out_last_q   <= stat_o.last_entry;
    end else if (cmd_i.out_resp) begin
      out_status_q <= cmd_i.resp_status;
      out_last_q   <= 1'b1;
      if (cmd_i.resp_status == cltt_pkg::ST_EMPTY) begin
        out_id_q   <= '0;
        out_wait_q <= wait_q;
      end else begin
        out_id_q   <= req_id_q;
        out_wait_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_wait_o   = out_wait_q;
  assign out_last_o   = out_last_q;

  // status to controller
  always_comb begin
    stat_o.cnt_nz       = (cnt_q != '0);
    stat_o.cnt_lt_count = (cnt_q < count_q);
    stat_o.match        = (rd_id_q == req_id_q);
    stat_o.full         = (count_q == CntW'(MaxClients));
    stat_o.count_zero   = (count_q == '0);
    stat_o.found        = found_q;
    stat_o.out_free     = !out_valid_q || out_ready_i;
    stat_o.shift_more   = (cnt_nxt < count_q);
    stat_o.last_entry   = (cnt_nxt == count_q);
    stat_o.req_cmd      = req_cmd_q;
  end

endmodule

// ===== rtl/client_liveness_timeout_table.sv =====
// Top level of the client liveness timeout table.
// Depends on cltt_pkg, cltt_req_if, cltt_rsp_if, cltt_ctrl and cltt_dp.
//
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    command, client_id, now_ms
//   rsp_if    out   valid/ready    status, entry_id, next_wait_ms, last
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_wdata_i (no read-back)
//
// One request is in work at a time.
// Add and seen: a search reads one entry a cycle through the memory's
//   registered port, then a single result is sent.
// Remove: the search, then a read and a write state per entry moved down.
// Tick: a minimum pass, then one result a cycle while the sink keeps up.
// Reset empties the table through the fill count; no clearing pass is needed.
// A stalled result sink holds the sequencer; requests wait in IDLE only.
module client_liveness_timeout_table #(
  parameter int unsigned MaxClients = cltt_pkg::MaxClientsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cltt_req_if.sink                      req_if,
  cltt_rsp_if.source                    rsp_if,
  input  logic                          cfg_we_i,
  input  logic [cltt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cltt_pkg::TimeW-1:0]    cfg_wdata_i
);

  cltt_pkg::ctrl_cmd_t ctrl_cmd;
  cltt_pkg::dp_stat_t  dp_stat;
  cltt_pkg::cmd_e      in_cmd;

  assign in_cmd = cltt_pkg::cmd_e'(req_if.command);

  // sequencer: owns the state, decides what the datapath does each cycle
  cltt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_if.valid),
    .in_cmd_i   (in_cmd),
    .in_ready_o (req_if.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // datapath: entry memories, counters, timing arithmetic and result register
  cltt_dp #(
    .MaxClients (MaxClients)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (in_cmd),
    .in_id_i      (req_if.client_id),
    .in_now_i     (req_if.now_ms),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .out_ready_i  (rsp_if.ready),
    .out_valid_o  (rsp_if.valid),
    .out_status_o (rsp_if.status),
    .out_id_o     (rsp_if.entry_id),
    .out_wait_o   (rsp_if.next_wait_ms),
    .out_last_o   (rsp_if.last)
  );

endmodule

// ===== rtl/cltt_checker.sv =====
// Port-level checks for the client liveness timeout table, bound to the top.
// Depends on cltt_pkg and client_liveness_timeout_table.
module cltt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [cltt_pkg::StatusW-1:0]  out_status_i,
  input logic [cltt_pkg::IdW-1:0]      out_id_i,
  input logic [cltt_pkg::TimeW-1:0]    out_wait_i,
  input logic                          out_last_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_id_i) && $stable(out_wait_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // single-result answers close the request and carry no wait
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == cltt_pkg::ST_OK || out_status_i == cltt_pkg::ST_FAIL)
      |-> out_last_i && out_wait_i == '0)
    else $error("add/remove/seen result malformed");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == cltt_pkg::ST_EMPTY |-> out_last_i && out_id_i == '0)
    else $error("empty tick result malformed");

  // mid-scan no new request is taken
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("request accepted during a scan");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready straight after acceptance");

endmodule

bind client_liveness_timeout_table cltt_checker u_cltt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_if.valid),
  .in_ready_i   (req_if.ready),
  .out_valid_i  (rsp_if.valid),
  .out_ready_i  (rsp_if.ready),
  .out_status_i (rsp_if.status),
  .out_id_i     (rsp_if.entry_id),
  .out_wait_i   (rsp_if.next_wait_ms),
  .out_last_i   (rsp_if.last)
);
